### hdl/olir_pkg.sv
// Shared types and constants of the ordered list block.
package olir_pkg;

  localparam int unsigned REQ_W    = 2;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned ITEM_W   = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned FILL_W   = 7;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT     = 2'd0,
    REQ_REMOVE_POS = 2'd1,
    REQ_REMOVE_VAL = 2'd2,
    REQ_TRAVERSE   = 2'd3
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_BADPOS   = 3'd2,
    ST_NULL     = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_EMPTY    = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_EXEC   = 2'd1,
    S_SEARCH = 2'd2,
    S_EMIT   = 2'd3
  } state_e;

  typedef struct packed {
    logic load_req;
    logic cap_match;
    logic apply;
    logic emit;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_search;
    logic is_walk;
    logic walk_last;
    logic out_free;
  } ctl_sts_t;

endpackage

### hdl/olir_ctrl.sv
// Request sequencer of the ordered list block.
module olir_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  olir_pkg::ctl_sts_t  sts_i,
  output olir_pkg::ctl_cmd_t  cmd_o
);

  olir_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= olir_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      olir_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = olir_pkg::S_EXEC;
        end
      end
      olir_pkg::S_EXEC: begin
        priority if (sts_i.is_search) begin
          state_d = olir_pkg::S_SEARCH;
        end else if (sts_i.is_walk) begin
          state_d = olir_pkg::S_EMIT;
        end else if (sts_i.out_free) begin
          state_d = olir_pkg::S_IDLE;
        end else begin
          state_d = olir_pkg::S_EXEC;
        end
      end
      olir_pkg::S_SEARCH: begin
        if (sts_i.out_free) begin
          state_d = olir_pkg::S_IDLE;
        end
      end
      olir_pkg::S_EMIT: begin
        if (sts_i.out_free && sts_i.walk_last) begin
          state_d = olir_pkg::S_IDLE;
        end
      end
      default: state_d = olir_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      olir_pkg::S_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.load_req = in_valid_i;
      end
      olir_pkg::S_EXEC: begin
        cmd_o.cap_match = sts_i.is_search;
        cmd_o.apply     = !sts_i.is_search && !sts_i.is_walk && sts_i.out_free;
      end
      olir_pkg::S_SEARCH: begin
        cmd_o.apply = sts_i.out_free;
      end
      olir_pkg::S_EMIT: begin
        cmd_o.emit = sts_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

### hdl/olir_dpath.sv
// Entry cells, fill count, match search and result register of the ordered list.
module olir_dpath #(
  parameter int unsigned DEPTH       = 16,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  olir_pkg::ctl_cmd_t                 cmd_i,
  output olir_pkg::ctl_sts_t                 sts_o,
  input  logic [olir_pkg::REQ_W-1:0]         req_type_i,
  input  logic [olir_pkg::POS_W-1:0]         position_i,
  input  logic [olir_pkg::ITEM_W-1:0]        item_value_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [olir_pkg::STATUS_W-1:0]      status_o,
  output logic [olir_pkg::ITEM_W-1:0]        out_value_o,
  output logic [olir_pkg::POS_W-1:0]         out_index_o,
  output logic [olir_pkg::FILL_W-1:0]        fill_count_o,
  output logic                               last_o
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CMP_W = olir_pkg::FILL_W;

  olir_pkg::req_e                 req_q;
  logic [olir_pkg::POS_W-1:0]     pos_q;
  logic [VALUE_WIDTH-1:0]         val_q;
  logic [CNT_W-1:0]               count_q, count_d;
  logic [VALUE_WIDTH-1:0]         cells_q [DEPTH];
  logic [VALUE_WIDTH-1:0]         cells_d [DEPTH];
  logic [DEPTH-1:0]               match_q, match_d;
  logic [IDX_W-1:0]               walk_q;

  logic                           out_valid_q;
  logic [olir_pkg::STATUS_W-1:0]  status_q;
  logic [olir_pkg::ITEM_W-1:0]    out_value_q;
  logic [olir_pkg::POS_W-1:0]     out_index_q;
  logic [olir_pkg::FILL_W-1:0]    fill_q;
  logic                           last_q;

  logic [VALUE_WIDTH+olir_pkg::ITEM_W-1:0] in_ext, cell_ext;
  logic [CMP_W+CNT_W-1:0]                  cnt_ext, cnt_next_ext;
  logic [CMP_W+IDX_W-1:0]                  walk_ext, first_ext;
  logic [CMP_W-1:0]                        count_c, pos_c, ins_c, walk_c, first_c;
  logic                                    val_null, list_empty, list_full, found;
  logic [IDX_W-1:0]                        ins_idx, del_idx, first_idx;
  logic                                    do_ins, do_del;
  olir_pkg::status_e                       res_status;
  logic [CMP_W-1:0]                        res_idx;
  logic                                    walk_last;
  logic                                    out_free;

  assign in_ext   = {{olir_pkg::ITEM_W{1'b0}}, item_value_i};
  assign cell_ext = {{olir_pkg::ITEM_W{1'b0}}, cells_q[walk_q]};
  assign cnt_ext  = {{CMP_W{1'b0}}, count_q};
  assign walk_ext = {{CMP_W{1'b0}}, walk_q};
  assign count_c  = cnt_ext[CMP_W-1:0];
  assign walk_c   = walk_ext[CMP_W-1:0];
  assign pos_c    = {1'b0, pos_q};

  assign val_null   = (val_q == '0);
  assign list_empty = (count_q == '0);
  assign list_full  = (int'(count_c) >= int'(DEPTH));
  assign ins_c      = (pos_c > count_c) ? count_c : pos_c;
  assign ins_idx    = ins_c[IDX_W-1:0];
  assign found      = |match_q;
  assign walk_last  = ((walk_c + CMP_W'(1)) == count_c);
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    first_idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (match_q[i]) begin
        first_idx = IDX_W'(i);
      end
    end
  end

  assign first_ext = {{CMP_W{1'b0}}, first_idx};
  assign first_c   = first_ext[CMP_W-1:0];

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      match_d[i] = (cells_q[i] == val_q) && (i < int'(count_c));
    end
  end

  always_comb begin
    res_status = olir_pkg::ST_OK;
    res_idx    = '0;
    do_ins     = 1'b0;
    do_del     = 1'b0;
    del_idx    = pos_q[IDX_W-1:0];
    unique case (req_q)
      olir_pkg::REQ_INSERT: begin
        priority if (val_null) begin
          res_status = olir_pkg::ST_NULL;
        end else if (list_full) begin
          res_status = olir_pkg::ST_FULL;
        end else begin
          do_ins  = 1'b1;
          res_idx = ins_c;
        end
      end
      olir_pkg::REQ_REMOVE_POS: begin
        priority if (list_empty) begin
          res_status = olir_pkg::ST_EMPTY;
        end else if (pos_c >= count_c) begin
          res_status = olir_pkg::ST_BADPOS;
        end else begin
          do_del  = 1'b1;
          res_idx = pos_c;
        end
      end
      olir_pkg::REQ_REMOVE_VAL: begin
        del_idx = first_idx;
        priority if (val_null) begin
          res_status = olir_pkg::ST_NULL;
        end else if (list_empty) begin
          res_status = olir_pkg::ST_EMPTY;
        end else if (!found) begin
          res_status = olir_pkg::ST_NOTFOUND;
        end else begin
          do_del  = 1'b1;
          res_idx = first_c;
        end
      end
      olir_pkg::REQ_TRAVERSE: begin
        res_status = olir_pkg::ST_EMPTY;
      end
      default: res_status = olir_pkg::ST_OK;
    endcase
  end

  always_comb begin
    cells_d = cells_q;
    count_d = count_q;
    if (cmd_i.apply && do_ins) begin
      for (int i = 1; i < DEPTH; i++) begin
        if (i > int'(ins_idx)) begin
          cells_d[i] = cells_q[i-1];
        end
      end
      cells_d[ins_idx] = val_q;
      count_d          = count_q + CNT_W'(1);
    end else if (cmd_i.apply && do_del) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        if (i >= int'(del_idx)) begin
          cells_d[i] = cells_q[i+1];
        end
      end
      count_d = count_q - CNT_W'(1);
    end
  end

  assign cnt_next_ext = {{CMP_W{1'b0}}, count_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (cmd_i.apply || cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cells_q <= cells_d;
    if (cmd_i.load_req) begin
      req_q  <= olir_pkg::req_e'(req_type_i);
      pos_q  <= position_i;
      val_q  <= in_ext[VALUE_WIDTH-1:0];
      walk_q <= '0;
    end else if (cmd_i.emit) begin
      walk_q <= walk_q + IDX_W'(1);
    end
    if (cmd_i.cap_match) begin
      match_q <= match_d;
    end
    if (cmd_i.apply) begin
      status_q    <= res_status;
      out_value_q <= '0;
      out_index_q <= res_idx[olir_pkg::POS_W-1:0];
      fill_q      <= cnt_next_ext[CMP_W-1:0];
      last_q      <= 1'b1;
    end else if (cmd_i.emit) begin
      status_q    <= olir_pkg::ST_OK;
      out_value_q <= cell_ext[olir_pkg::ITEM_W-1:0];
      out_index_q <= walk_c[olir_pkg::POS_W-1:0];
      fill_q      <= count_c;
      last_q      <= walk_last;
    end
  end

  assign sts_o.is_search = (req_q == olir_pkg::REQ_REMOVE_VAL) && !val_null && !list_empty;
  assign sts_o.is_walk   = (req_q == olir_pkg::REQ_TRAVERSE) && !list_empty;
  assign sts_o.walk_last = walk_last;
  assign sts_o.out_free  = out_free;

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign out_value_o  = out_value_q;
  assign out_index_o  = out_index_q;
  assign fill_count_o = fill_q;
  assign last_o       = last_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(count_c) <= int'(DEPTH))
    else $error("fill count beyond depth");

  a_count_on_apply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> $past(cmd_i.apply))
    else $error("fill count changed without a request being applied");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.apply || cmd_i.emit) |-> out_free)
    else $error("result register overwritten while occupied");

  a_single_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.apply && cmd_i.emit))
    else $error("apply and emit in the same cycle");

  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (walk_c < count_c))
    else $error("traverse index beyond fill count");

endmodule

### hdl/ordered_list_insert_remove.sv
// Top level of the ordered list with positional insert and remove.
//
//   channel | direction | words
//   in      | input     | req_type, position, item_value
//   out     | output    | status, out_value, out_index, fill_count, last
//
// Insert and remove-at-position: accept, then an apply step that shifts the cells from the target
// index on. Remove-by-value adds a step that registers the compare vector before the
// priority pick. Traverse: accept, a decode step, then one emitted word per cycle while the
// output is free.
// Reset clears the fill count and the control state; the cells hold no reset value.
// A stalled output holds the sequencer; a new word is taken while a result still waits.
module ordered_list_insert_remove #(
  parameter int unsigned DEPTH       = 16,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [olir_pkg::REQ_W-1:0]     req_type_i,
  input  logic [olir_pkg::POS_W-1:0]     position_i,
  input  logic [olir_pkg::ITEM_W-1:0]    item_value_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [olir_pkg::STATUS_W-1:0]  status_o,
  output logic [olir_pkg::ITEM_W-1:0]    out_value_o,
  output logic [olir_pkg::POS_W-1:0]     out_index_o,
  output logic [olir_pkg::FILL_W-1:0]    fill_count_o,
  output logic                           last_o
);

  olir_pkg::ctl_cmd_t cmd;
  olir_pkg::ctl_sts_t sts;

  olir_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  olir_dpath #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .req_type_i   (req_type_i),
    .position_i   (position_i),
    .item_value_i (item_value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .out_value_o  (out_value_o),
    .out_index_o  (out_index_o),
    .fill_count_o (fill_count_o),
    .last_o       (last_o)
  );

endmodule

### verif/ordered_list_insert_remove_tb.sv
// Self-checking testbench for the ordered list with positional insert and remove.
module ordered_list_insert_remove_tb;

  localparam int unsigned LIST_DEPTH = 16;

  typedef struct {
    olir_pkg::status_e           status;
    logic [olir_pkg::ITEM_W-1:0] value;
    logic [olir_pkg::POS_W-1:0]  index;
    logic [olir_pkg::FILL_W-1:0] fill;
    logic                        last;
  } list_result_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_ready_o;
  logic [olir_pkg::REQ_W-1:0]    req_type_i;
  logic [olir_pkg::POS_W-1:0]    position_i;
  logic [olir_pkg::ITEM_W-1:0]   item_value_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  logic [olir_pkg::STATUS_W-1:0] status_o;
  logic [olir_pkg::ITEM_W-1:0]   out_value_o;
  logic [olir_pkg::POS_W-1:0]    out_index_o;
  logic [olir_pkg::FILL_W-1:0]   fill_count_o;
  logic                          last_o;

  logic [olir_pkg::ITEM_W-1:0] list_cells [LIST_DEPTH];
  int unsigned                 list_fill;
  list_result_t                due_results [$];
  list_result_t                want;
  logic [olir_pkg::ITEM_W-1:0] value_pool [8];
  int unsigned                 send_idle_pct;
  int unsigned                 recv_idle_pct;
  int unsigned                 recv_hold_left;
  int                          fail_count;

  ordered_list_insert_remove #(
    .DEPTH      (LIST_DEPTH),
    .VALUE_WIDTH(olir_pkg::ITEM_W)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .position_i  (position_i),
    .item_value_i(item_value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .out_value_o (out_value_o),
    .out_index_o (out_index_o),
    .fill_count_o(fill_count_o),
    .last_o      (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #400000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic void push_result(olir_pkg::status_e st,
                                      logic [olir_pkg::ITEM_W-1:0] val,
                                      int unsigned idx, logic fin);
    list_result_t r;
    r.status = st;
    r.value  = val;
    r.index  = idx[olir_pkg::POS_W-1:0];
    r.fill   = list_fill[olir_pkg::FILL_W-1:0];
    r.last   = fin;
    due_results.push_back(r);
  endfunction

  function automatic void drop_cell(int unsigned p);
    int unsigned i;
    for (i = p; i + 1 < list_fill; i++) list_cells[i] = list_cells[i + 1];
    list_fill--;
  endfunction

  function automatic void apply_request(olir_pkg::req_e req,
                                        logic [olir_pkg::POS_W-1:0] pos,
                                        logic [olir_pkg::ITEM_W-1:0] val);
    int unsigned p;
    int unsigned i;
    bit          hit;
    p   = pos;
    hit = 1'b0;
    case (req)
      olir_pkg::REQ_INSERT: begin
        if (val == '0) begin
          push_result(olir_pkg::ST_NULL, '0, 0, 1'b1);
        end else if (list_fill >= LIST_DEPTH) begin
          push_result(olir_pkg::ST_FULL, '0, 0, 1'b1);
        end else begin
          if (p > list_fill) p = list_fill;
          for (i = list_fill; i > p; i--) list_cells[i] = list_cells[i - 1];
          list_cells[p] = val;
          list_fill++;
          push_result(olir_pkg::ST_OK, '0, p, 1'b1);
        end
      end
      olir_pkg::REQ_REMOVE_POS: begin
        if (list_fill == 0) begin
          push_result(olir_pkg::ST_EMPTY, '0, 0, 1'b1);
        end else if (p >= list_fill) begin
          push_result(olir_pkg::ST_BADPOS, '0, 0, 1'b1);
        end else begin
          drop_cell(p);
          push_result(olir_pkg::ST_OK, '0, p, 1'b1);
        end
      end
      olir_pkg::REQ_REMOVE_VAL: begin
        if (val == '0) begin
          push_result(olir_pkg::ST_NULL, '0, 0, 1'b1);
        end else if (list_fill == 0) begin
          push_result(olir_pkg::ST_EMPTY, '0, 0, 1'b1);
        end else begin
          for (i = 0; i < list_fill && !hit; i++) begin
            if (list_cells[i] == val) begin
              hit = 1'b1;
              drop_cell(i);
              push_result(olir_pkg::ST_OK, '0, i, 1'b1);
            end
          end
          if (!hit) push_result(olir_pkg::ST_NOTFOUND, '0, 0, 1'b1);
        end
      end
      default: begin
        if (list_fill == 0) begin
          push_result(olir_pkg::ST_EMPTY, '0, 0, 1'b1);
        end else begin
          for (i = 0; i < list_fill; i++) begin
            push_result(olir_pkg::ST_OK, list_cells[i], i, (i + 1 == list_fill));
          end
        end
      end
    endcase
  endfunction

  // Receiver: random stalls, or a long hold-off when requested.
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (recv_hold_left > 0) begin
        recv_hold_left--;
        out_ready_i = 1'b0;
      end else begin
        out_ready_i = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (due_results.size() == 0) begin
        $error("unexpected word: status %0d value %0h index %0d", status_o, out_value_o,
               out_index_o);
        fail_count++;
      end else begin
        want = due_results.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status_o);
          fail_count++;
        end
        if (out_value_o !== want.value) begin
          $error("out_value: expected %0h, actual %0h", want.value, out_value_o);
          fail_count++;
        end
        if (out_index_o !== want.index) begin
          $error("out_index: expected %0d, actual %0d", want.index, out_index_o);
          fail_count++;
        end
        if (fill_count_o !== want.fill) begin
          $error("fill_count: expected %0d, actual %0d", want.fill, fill_count_o);
          fail_count++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0b, actual %0b", want.last, last_o);
          fail_count++;
        end
      end
    end
  end

  task automatic send_word(olir_pkg::req_e req, logic [olir_pkg::POS_W-1:0] pos,
                           logic [olir_pkg::ITEM_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   = 1'b1;
    req_type_i   = req;
    position_i   = pos;
    item_value_i = val;
    do @(posedge clk_i); while (!in_ready_o);
    apply_request(req, pos, val);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic send_random_word();
    int unsigned                 roll;
    int unsigned                 ins_pct;
    olir_pkg::req_e              req;
    logic [olir_pkg::POS_W-1:0]  pos;
    logic [olir_pkg::ITEM_W-1:0] val;
    ins_pct = (list_fill < 4) ? 60 : ((list_fill > 12) ? 25 : 40);
    roll    = $urandom_range(99);
    if (roll < ins_pct) req = olir_pkg::REQ_INSERT;
    else if (roll < ins_pct + 25) req = olir_pkg::REQ_REMOVE_POS;
    else if (roll < ins_pct + 50) req = olir_pkg::REQ_REMOVE_VAL;
    else req = olir_pkg::REQ_TRAVERSE;
    if ($urandom_range(99) < 80) pos = olir_pkg::POS_W'($urandom_range(list_fill));
    else pos = olir_pkg::POS_W'($urandom_range(63));
    roll = $urandom_range(99);
    if (roll < 8) val = '0;
    else if (roll < 63) val = value_pool[$urandom_range(7)];
    else val = $urandom;
    send_word(req, pos, val);
  endtask

  task automatic wait_drained();
    while (due_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic test_empty_list();
    send_word(olir_pkg::REQ_TRAVERSE, 6'd0, 32'h0);
    send_word(olir_pkg::REQ_REMOVE_POS, 6'd0, 32'h0);
    send_word(olir_pkg::REQ_REMOVE_VAL, 6'd0, 32'hFFFF_FFFF);
    send_word(olir_pkg::REQ_REMOVE_VAL, 6'd63, 32'h0);
  endtask

  task automatic test_fill_to_full();
    int unsigned k;
    send_word(olir_pkg::REQ_INSERT, 6'd63, 32'hFFFF_FFFF);
    send_word(olir_pkg::REQ_INSERT, 6'd0, 32'h0000_0001);
    send_word(olir_pkg::REQ_INSERT, 6'd1, 32'h8000_0000);
    send_word(olir_pkg::REQ_INSERT, 6'd2, value_pool[0]);
    send_word(olir_pkg::REQ_INSERT, 6'd0, value_pool[0]);
    for (k = 5; k < LIST_DEPTH; k++) begin
      send_word(olir_pkg::REQ_INSERT, olir_pkg::POS_W'($urandom_range(k + 2)),
                value_pool[k % 8]);
    end
    send_word(olir_pkg::REQ_INSERT, 6'd0, 32'h0);
    send_word(olir_pkg::REQ_INSERT, 6'd63, 32'h5555_AAAA);
    send_word(olir_pkg::REQ_TRAVERSE, 6'd0, 32'h0);
  endtask

  task automatic test_removals();
    send_word(olir_pkg::REQ_REMOVE_POS, olir_pkg::POS_W'(LIST_DEPTH), 32'h0);
    send_word(olir_pkg::REQ_REMOVE_VAL, 6'd0, 32'h0000_0002);
    send_word(olir_pkg::REQ_REMOVE_VAL, 6'd0, value_pool[0]);
    send_word(olir_pkg::REQ_REMOVE_POS, 6'd0, 32'h0);
    send_word(olir_pkg::REQ_REMOVE_POS, olir_pkg::POS_W'(list_fill - 1), 32'h0);
    send_word(olir_pkg::REQ_TRAVERSE, 6'd0, 32'h0);
  endtask

  task automatic test_random_mix(int unsigned n);
    int unsigned k;
    for (k = 0; k < n; k++) send_random_word();
  endtask

  // Hold the receiver off while words keep coming so the block backs up.
  task automatic test_backpressure();
    int unsigned k;
    recv_hold_left = 150;
    for (k = 0; k < 12; k++) begin
      send_word(olir_pkg::REQ_INSERT, olir_pkg::POS_W'($urandom_range(63)),
                $urandom | 32'h1);
    end
    send_word(olir_pkg::REQ_TRAVERSE, 6'd0, 32'h0);
    test_random_mix(8);
  endtask

  initial begin
    int unsigned k;
    fail_count     = 0;
    list_fill      = 0;
    recv_hold_left = 0;
    send_idle_pct  = 8;
    recv_idle_pct  = 51;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    req_type_i     = olir_pkg::REQ_INSERT;
    position_i     = '0;
    item_value_i   = '0;
    value_pool[0]  = 32'hFFFF_FFFF;
    value_pool[1]  = 32'h0000_0001;
    value_pool[2]  = 32'h8000_0000;
    for (k = 3; k < 8; k++) value_pool[k] = $urandom | 32'h4;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_empty_list();
    test_fill_to_full();
    test_removals();
    test_random_mix(30);
    wait_drained();

    send_idle_pct = 51;
    recv_idle_pct = 8;
    test_random_mix(30);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_mix(20);
    test_backpressure();
    in_valid_i = 1'b0;
    wait_drained();
    repeat (LIST_DEPTH + 8) @(negedge clk_i);

    if (fail_count == 0 && due_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
